// ===== rtl/i2c_master_bit_sequencer_top_macros.svh =====
// Assertion macros for the I2C master bit sequencer.
// Expects clk and arst_n in the scope of the module that takes this header.
`ifndef I2C_MASTER_BIT_SEQUENCER_TOP_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CBS_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2c sequencer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define I2CBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2c sequencer: next-cycle check failed");

`endif

// ===== rtl/i2cbs_pkg.sv =====
// Shared constants and types for the I2C master bit sequencer.
// No dependencies; used by i2c_master_bit_sequencer_top.
`default_nettype none

package i2cbs_pkg;

	localparam int DATA_BITS  = 8;
	localparam int BIT_W      = $clog2(DATA_BITS);
	localparam int PHASE_W    = 2;
	localparam int CMD_W      = 3;
	localparam int HOLD_W     = 16;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd720;

	typedef enum logic [CMD_W-1:0] {
		CMD_START    = 3'd0,
		CMD_STOP     = 3'd1,
		CMD_WRITE    = 3'd2,
		CMD_READ     = 3'd3,
		CMD_SEND_ACK = 3'd4,
		CMD_READ_ACK = 3'd5
	} cmd_t;

	localparam logic [PHASE_W-1:0] PH_0 = 2'd0;
	localparam logic [PHASE_W-1:0] PH_1 = 2'd1;
	localparam logic [PHASE_W-1:0] PH_2 = 2'd2;
	localparam logic [PHASE_W-1:0] PH_3 = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/i2c_master_bit_sequencer_top.sv =====
// I2C master bit sequencer: turns bus commands into timed SCL/SDA line steps.
// Depends on i2cbs_pkg and i2c_master_bit_sequencer_top_macros.svh.
//
//   channel   handshake             payload
//   in        in_valid / in_stall   cmd, tx_byte, ack_out, slave_bits, slave_ack
//   out       out_valid / out_stall scl, sda, rx_byte, ack_in, last
//   cfg       cfg_valid / cfg_ready cfg_data (step_hold_cycles)
//
// Each line step is formed in ST_STEP, waits in the output register (ST_EMIT)
// until taken, then the hold counter runs down from step_hold_cycles (ST_HOLD)
// before the next step. A command takes 3 to 24 steps, and each output stall
// delays it further.
// Reset leaves both lines released high and step_hold_cycles at HOLD_RESET.
// A stall on the output freezes the step; no new command is taken until done.
`default_nettype none

module i2c_master_bit_sequencer_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [i2cbs_pkg::CMD_W-1:0]         cmd,
	input  wire logic [i2cbs_pkg::DATA_BITS-1:0]     tx_byte,
	input  wire logic                                ack_out,
	input  wire logic [i2cbs_pkg::DATA_BITS-1:0]     slave_bits,
	input  wire logic                                slave_ack,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     scl,
	output logic                                     sda,
	output logic [i2cbs_pkg::DATA_BITS-1:0]          rx_byte,
	output logic                                     ack_in,
	output logic                                     last,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [i2cbs_pkg::HOLD_W-1:0]        cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_EMIT,
		ST_HOLD
	} state_t;

	state_t                                 state_q;
	i2cbs_pkg::cmd_t                        cmd_q;
	logic [i2cbs_pkg::PHASE_W-1:0]          phase_q;
	logic [i2cbs_pkg::BIT_W-1:0]            bit_q;
	logic [i2cbs_pkg::DATA_BITS-1:0]        data_q;
	logic [i2cbs_pkg::DATA_BITS-1:0]        rx_q;
	logic                                   ackbit_q;
	logic [i2cbs_pkg::HOLD_W-1:0]           hold_cfg_q;
	logic [i2cbs_pkg::HOLD_W-1:0]           hold_q;
	logic                                   scl_q;
	logic                                   sda_q;
	logic [i2cbs_pkg::DATA_BITS-1:0]        rx_out_q;
	logic                                   ack_out_q;
	logic                                   last_q;

	logic                                   n_scl;
	logic                                   n_sda;
	logic                                   n_last;
	logic [i2cbs_pkg::DATA_BITS-1:0]        n_rx;
	logic                                   n_ack;
	logic [i2cbs_pkg::PHASE_W-1:0]          n_phase;
	logic                                   n_bit_inc;
	logic                                   shift_en;
	logic                                   sample_en;
	logic                                   in_take;
	logic                                   out_take;
	logic                                   bit_final;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign cfg_ready = 1'b1;
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid && !out_stall;
	assign bit_final = (bit_q == i2cbs_pkg::BIT_W'(i2cbs_pkg::DATA_BITS - 1));

	assign scl     = scl_q;
	assign sda     = sda_q;
	assign rx_byte = rx_out_q;
	assign ack_in  = ack_out_q;
	assign last    = last_q;

	always_comb begin
		n_scl     = scl_q;
		n_sda     = sda_q;
		n_last    = 1'b0;
		n_rx      = '0;
		n_ack     = 1'b0;
		n_phase   = phase_q + 1'b1;
		n_bit_inc = 1'b0;
		shift_en  = 1'b0;
		sample_en = 1'b0;
		unique case (cmd_q)
			i2cbs_pkg::CMD_START: begin
				case (phase_q)
					i2cbs_pkg::PH_0: n_sda = 1'b1;
					i2cbs_pkg::PH_1: n_scl = 1'b1;
					i2cbs_pkg::PH_2: n_sda = 1'b0;
					default: begin
						n_scl  = 1'b0;
						n_last = 1'b1;
					end
				endcase
			end
			i2cbs_pkg::CMD_STOP: begin
				case (phase_q)
					i2cbs_pkg::PH_0: n_sda = 1'b0;
					i2cbs_pkg::PH_1: n_scl = 1'b1;
					default: begin
						n_sda  = 1'b1;
						n_last = 1'b1;
					end
				endcase
			end
			i2cbs_pkg::CMD_WRITE: begin
				case (phase_q)
					i2cbs_pkg::PH_0: begin
						n_sda    = data_q[i2cbs_pkg::DATA_BITS-1];
						shift_en = 1'b1;
					end
					i2cbs_pkg::PH_1: n_scl = 1'b1;
					default: begin
						n_scl     = 1'b0;
						n_last    = bit_final;
						n_phase   = i2cbs_pkg::PH_0;
						n_bit_inc = 1'b1;
					end
				endcase
			end
			i2cbs_pkg::CMD_READ: begin
				case (phase_q)
					i2cbs_pkg::PH_0: n_sda = 1'b1;
					i2cbs_pkg::PH_1: begin
						n_scl     = 1'b1;
						shift_en  = 1'b1;
						sample_en = 1'b1;
					end
					default: begin
						n_scl     = 1'b0;
						n_last    = bit_final;
						n_rx      = bit_final ? rx_q : '0;
						n_phase   = i2cbs_pkg::PH_1;
						n_bit_inc = 1'b1;
					end
				endcase
			end
			i2cbs_pkg::CMD_SEND_ACK, i2cbs_pkg::CMD_READ_ACK: begin
				case (phase_q)
					i2cbs_pkg::PH_0: n_sda = (cmd_q == i2cbs_pkg::CMD_SEND_ACK) ? ackbit_q : 1'b1;
					i2cbs_pkg::PH_1: n_scl = 1'b1;
					default: begin
						n_scl  = 1'b0;
						n_last = 1'b1;
						n_ack  = (cmd_q == i2cbs_pkg::CMD_READ_ACK) ? ackbit_q : 1'b0;
					end
				endcase
			end
			default: n_last = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cfg_q <= i2cbs_pkg::HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			hold_cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q    <= i2cbs_pkg::cmd_t'(cmd);
			data_q   <= (cmd == i2cbs_pkg::CMD_READ) ? slave_bits : tx_byte;
			ackbit_q <= (cmd == i2cbs_pkg::CMD_SEND_ACK) ? ack_out : slave_ack;
			rx_q     <= '0;
		end else if (state_q == ST_STEP) begin
			if (shift_en) begin
				data_q <= {data_q[i2cbs_pkg::DATA_BITS-2:0], 1'b0};
			end
			if (sample_en) begin
				rx_q <= {rx_q[i2cbs_pkg::DATA_BITS-2:0], data_q[i2cbs_pkg::DATA_BITS-1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= i2cbs_pkg::PH_0;
			bit_q     <= '0;
			hold_q    <= '0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			rx_out_q  <= '0;
			ack_out_q <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take && (cmd <= i2cbs_pkg::CMD_READ_ACK)) begin
						phase_q <= i2cbs_pkg::PH_0;
						bit_q   <= '0;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					scl_q     <= n_scl;
					sda_q     <= n_sda;
					rx_out_q  <= n_rx;
					ack_out_q <= n_ack;
					last_q    <= n_last;
					phase_q   <= n_phase;
					if (n_bit_inc) begin
						bit_q <= bit_q + 1'b1;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_take) begin
						hold_q  <= hold_cfg_q;
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					hold_q <= hold_q - 1'b1;
					if (hold_q <= i2cbs_pkg::HOLD_W'(1)) begin
						state_q <= last_q ? ST_IDLE : ST_STEP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`include "i2c_master_bit_sequencer_top_macros.svh"

	`I2CBS_ASSERT_NEXT(a_gap_after_step, out_valid && !out_stall, !out_valid)
	`I2CBS_ASSERT_IMPLIES(a_busy_while_emit, out_valid, in_stall)
	`I2CBS_ASSERT_IMPLIES(a_phase3_start, (state_q == ST_STEP) && (phase_q == i2cbs_pkg::PH_3), cmd_q == i2cbs_pkg::CMD_START)
	`I2CBS_ASSERT_IMPLIES(a_one_line_moves, $rose(scl) || $fell(scl), $stable(sda))

endmodule

`default_nettype wire

// ===== tb/i2c_master_bit_sequencer_top_test.sv =====
// Self-checking testbench for i2c_master_bit_sequencer_top: commands in, line steps out.
// A scoreboard class predicts every line step. Plain tasks drive the command and hold ports.
// Depends on i2cbs_pkg and the RTL of the block only.
`default_nettype none

module i2c_master_bit_sequencer_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [i2cbs_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [i2cbs_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;
	localparam int                          WATCHDOG_LIMIT = 300000;

	typedef struct packed {
		logic                            scl;
		logic                            sda;
		logic [i2cbs_pkg::DATA_BITS-1:0] rx_byte;
		logic                            ack_in;
		logic                            last;
	} line_step_t;

	class line_step_scoreboard;
		line_step_t                      due_steps[$];
		logic                            scl_lvl = 1'b1;
		logic                            sda_lvl = 1'b1;
		logic [i2cbs_pkg::DATA_BITS-1:0] shift_q = '0;
		int                              mismatches = 0;
		int                              steps_seen = 0;
		int                              cmds_seen[8];

		function int pending();
			return due_steps.size();
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 100)
				$display("[%0t] ERROR: %s", $time, msg);
		endtask

		function void emit_step(logic [i2cbs_pkg::DATA_BITS-1:0] rx, logic ack, logic fin);
			line_step_t s;
			s.scl = scl_lvl;
			s.sda = sda_lvl;
			s.rx_byte = rx;
			s.ack_in = ack;
			s.last = fin;
			due_steps.push_back(s);
		endfunction

		function void predict_line_steps(logic [i2cbs_pkg::CMD_W-1:0] c,
				logic [i2cbs_pkg::DATA_BITS-1:0] tx, logic ackv,
				logic [i2cbs_pkg::DATA_BITS-1:0] sbits, logic sack);
			cmds_seen[c]++;
			case (c)
				i2cbs_pkg::CMD_START: begin
					sda_lvl = 1'b1; emit_step('0, 1'b0, 1'b0);
					scl_lvl = 1'b1; emit_step('0, 1'b0, 1'b0);
					sda_lvl = 1'b0; emit_step('0, 1'b0, 1'b0);
					scl_lvl = 1'b0; emit_step('0, 1'b0, 1'b1);
				end
				i2cbs_pkg::CMD_STOP: begin
					sda_lvl = 1'b0; emit_step('0, 1'b0, 1'b0);
					scl_lvl = 1'b1; emit_step('0, 1'b0, 1'b0);
					sda_lvl = 1'b1; emit_step('0, 1'b0, 1'b1);
				end
				i2cbs_pkg::CMD_WRITE: begin
					shift_q = tx;
					for (int i = i2cbs_pkg::DATA_BITS - 1; i >= 0; i--) begin
						sda_lvl = tx[i]; emit_step('0, 1'b0, 1'b0);
						scl_lvl = 1'b1; emit_step('0, 1'b0, 1'b0);
						scl_lvl = 1'b0; emit_step('0, 1'b0, i == 0);
					end
				end
				i2cbs_pkg::CMD_READ: begin
					shift_q = '0;
					sda_lvl = 1'b1; emit_step('0, 1'b0, 1'b0);
					for (int i = i2cbs_pkg::DATA_BITS - 1; i >= 0; i--) begin
						scl_lvl = 1'b1; emit_step('0, 1'b0, 1'b0);
						shift_q[i] = sbits[i];
						scl_lvl = 1'b0; emit_step((i == 0) ? shift_q : '0, 1'b0, i == 0);
					end
				end
				i2cbs_pkg::CMD_SEND_ACK: begin
					sda_lvl = ackv; emit_step('0, 1'b0, 1'b0);
					scl_lvl = 1'b1; emit_step('0, 1'b0, 1'b0);
					scl_lvl = 1'b0; emit_step('0, 1'b0, 1'b1);
				end
				i2cbs_pkg::CMD_READ_ACK: begin
					sda_lvl = 1'b1; emit_step('0, 1'b0, 1'b0);
					scl_lvl = 1'b1; emit_step('0, 1'b0, 1'b0);
					scl_lvl = 1'b0; emit_step('0, sack, 1'b1);
				end
				default: begin
				end
			endcase
		endfunction

		task check_step(line_step_t got);
			line_step_t want;
			steps_seen++;
			if (due_steps.size() == 0) begin
				report($sformatf("line step %0d arrived with none expected", steps_seen));
			end else begin
				want = due_steps.pop_front();
				if (got.scl !== want.scl)
					report($sformatf("step %0d scl %b, expected %b", steps_seen, got.scl, want.scl));
				if (got.sda !== want.sda)
					report($sformatf("step %0d sda %b, expected %b", steps_seen, got.sda, want.sda));
				if (got.rx_byte !== want.rx_byte)
					report($sformatf("step %0d rx_byte %h, expected %h", steps_seen,
						got.rx_byte, want.rx_byte));
				if (got.ack_in !== want.ack_in)
					report($sformatf("step %0d ack_in %b, expected %b", steps_seen,
						got.ack_in, want.ack_in));
				if (got.last !== want.last)
					report($sformatf("step %0d last %b, expected %b", steps_seen,
						got.last, want.last));
			end
		endtask
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [i2cbs_pkg::CMD_W-1:0]     cmd = '0;
	logic [i2cbs_pkg::DATA_BITS-1:0] tx_byte = '0;
	logic                            ack_out = 1'b0;
	logic [i2cbs_pkg::DATA_BITS-1:0] slave_bits = '0;
	logic                            slave_ack = 1'b0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic                            scl;
	logic                            sda;
	logic [i2cbs_pkg::DATA_BITS-1:0] rx_byte;
	logic                            ack_in;
	logic                            last;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [i2cbs_pkg::HOLD_W-1:0]    cfg_data = '0;

	line_step_scoreboard  sb = new();
	bit                   steady = 1'b0;
	int                   hold_now = int'(i2cbs_pkg::HOLD_RESET);
	int                   hold_settings = 1;
	int                   phase_items = 0;
	int                   idle_cycles = 0;

	i2c_master_bit_sequencer_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.tx_byte    (tx_byte),
		.ack_out    (ack_out),
		.slave_bits (slave_bits),
		.slave_ack  (slave_ack),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.scl        (scl),
		.sda        (sda),
		.rx_byte    (rx_byte),
		.ack_in     (ack_in),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 32);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_step('{scl: scl, sda: sda, rx_byte: rx_byte, ack_in: ack_in, last: last});
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("[%0t] ERROR: no transaction for %0d cycles", $time, idle_cycles);
					$display("i2c_master_bit_sequencer_top: mismatch");
					$finish;
				end
			end
		end
	end

	task automatic issue(logic [i2cbs_pkg::CMD_W-1:0] c, logic [i2cbs_pkg::DATA_BITS-1:0] tx,
			logic ackv, logic [i2cbs_pkg::DATA_BITS-1:0] sbits, logic sack);
		while (!steady && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			cmd <= i2cbs_pkg::CMD_W'($urandom);
			tx_byte <= i2cbs_pkg::DATA_BITS'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		tx_byte <= tx;
		ack_out <= ackv;
		slave_bits <= sbits;
		slave_ack <= sack;
		do @(posedge clk); while (in_stall);
		sb.predict_line_steps(c, tx, ackv, sbits, sack);
		if (c <= i2cbs_pkg::CMD_READ_ACK)
			phase_items++;
		@(negedge clk);
	endtask

	task automatic issue_rand(logic [i2cbs_pkg::CMD_W-1:0] c);
		issue(c, i2cbs_pkg::DATA_BITS'($urandom), 1'($urandom),
			i2cbs_pkg::DATA_BITS'($urandom), 1'($urandom));
	endtask

	task automatic drain();
		while (sb.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_hold(logic [i2cbs_pkg::HOLD_W-1:0] v);
		in_valid <= 1'b0;
		drain();
		repeat (hold_now + 8) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		hold_now = int'(v);
		hold_settings++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic bus_transaction();
		logic [i2cbs_pkg::DATA_BITS-1:0] addr;
		int                              n;
		addr = i2cbs_pkg::DATA_BITS'($urandom);
		n = $urandom_range(1, 3);
		issue_rand(i2cbs_pkg::CMD_START);
		issue_rand(i2cbs_pkg::CMD_WRITE);
		issue(i2cbs_pkg::CMD_WRITE, addr, 1'($urandom), i2cbs_pkg::DATA_BITS'($urandom),
			1'($urandom));
		issue_rand(i2cbs_pkg::CMD_READ_ACK);
		for (int k = 0; k < n; k++) begin
			if (addr[0]) begin
				issue_rand(i2cbs_pkg::CMD_READ);
				issue(i2cbs_pkg::CMD_SEND_ACK, i2cbs_pkg::DATA_BITS'($urandom), k == n - 1,
					i2cbs_pkg::DATA_BITS'($urandom), 1'($urandom));
			end else begin
				issue_rand(i2cbs_pkg::CMD_WRITE);
				issue_rand(i2cbs_pkg::CMD_READ_ACK);
			end
		end
		issue_rand(i2cbs_pkg::CMD_STOP);
	endtask

	task automatic random_phase(int target, bit pause_midway);
		phase_items = 0;
		while (phase_items < target) begin
			if (pause_midway && phase_items >= target / 2) begin
				pause_midway = 1'b0;
				in_valid <= 1'b0;
				drain();
			end
			if ($urandom_range(0, 99) < 75)
				bus_transaction();
			else
				issue_rand(i2cbs_pkg::CMD_W'($urandom_range(0, 7)));
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		issue_rand(i2cbs_pkg::CMD_START);
		issue_rand(i2cbs_pkg::CMD_STOP);
		set_hold(16'd1);

		issue_rand(i2cbs_pkg::CMD_START);
		issue_rand(i2cbs_pkg::CMD_START);
		issue(i2cbs_pkg::CMD_WRITE, 8'h00, 1'b1, 8'hFF, 1'b1);
		issue(i2cbs_pkg::CMD_WRITE, 8'hFF, 1'b0, 8'h00, 1'b0);
		issue(i2cbs_pkg::CMD_WRITE, 8'hA5, 1'b0, 8'h5A, 1'b0);
		issue(i2cbs_pkg::CMD_WRITE, 8'h01, 1'b1, 8'h80, 1'b1);
		issue(i2cbs_pkg::CMD_READ, 8'hFF, 1'b1, 8'h00, 1'b1);
		issue(i2cbs_pkg::CMD_READ, 8'h00, 1'b0, 8'hFF, 1'b0);
		issue(i2cbs_pkg::CMD_READ, 8'h3C, 1'b0, 8'h5A, 1'b1);
		issue(i2cbs_pkg::CMD_READ, 8'h7F, 1'b1, 8'h80, 1'b0);
		issue(i2cbs_pkg::CMD_SEND_ACK, 8'hFF, 1'b0, 8'hFF, 1'b1);
		issue(i2cbs_pkg::CMD_SEND_ACK, 8'h00, 1'b1, 8'h00, 1'b0);
		issue(i2cbs_pkg::CMD_READ_ACK, 8'hFF, 1'b1, 8'hFF, 1'b0);
		issue(i2cbs_pkg::CMD_READ_ACK, 8'h00, 1'b0, 8'h00, 1'b1);
		issue(CMD_SPARE_A, 8'hFF, 1'b1, 8'hFF, 1'b1);
		issue(CMD_SPARE_B, 8'h00, 1'b0, 8'h00, 1'b0);
		issue_rand(i2cbs_pkg::CMD_STOP);
		issue_rand(i2cbs_pkg::CMD_STOP);
		issue_rand(i2cbs_pkg::CMD_START);
		issue_rand(i2cbs_pkg::CMD_STOP);
		issue_rand(CMD_SPARE_B);
		issue_rand(i2cbs_pkg::CMD_READ_ACK);

		set_hold(i2cbs_pkg::HOLD_W'($urandom_range(1, 4)));
		random_phase(40, 1'b1);
		set_hold(i2cbs_pkg::HOLD_W'($urandom_range(2, 8)));
		steady = 1'b1;
		random_phase(40, 1'b0);
		steady = 1'b0;
		set_hold(i2cbs_pkg::HOLD_W'($urandom_range(1, 3)));
		random_phase(40, 1'b0);

		set_hold(16'hFFFF);
		issue_rand(i2cbs_pkg::CMD_SEND_ACK);
		in_valid <= 1'b0;

		drain();
		repeat (hold_now + 8) @(posedge clk);
		$display("Ran %0d start, %0d stop, %0d write, %0d read, %0d send-ack, %0d read-ack",
			sb.cmds_seen[i2cbs_pkg::CMD_START], sb.cmds_seen[i2cbs_pkg::CMD_STOP],
			sb.cmds_seen[i2cbs_pkg::CMD_WRITE], sb.cmds_seen[i2cbs_pkg::CMD_READ],
			sb.cmds_seen[i2cbs_pkg::CMD_SEND_ACK], sb.cmds_seen[i2cbs_pkg::CMD_READ_ACK]);
		$display("plus %0d undefined ones; %0d line steps checked over %0d hold times, 1 to 65535.",
			sb.cmds_seen[CMD_SPARE_A] + sb.cmds_seen[CMD_SPARE_B], sb.steps_seen, hold_settings);
		if (sb.mismatches == 0) begin
			$display("i2c_master_bit_sequencer_top: match");
		end else begin
			$display("i2c_master_bit_sequencer_top: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
